@@ rtl/core/tot_pkg.sv @@
// Shared types and constants for the tile overlap trimmer.
// No dependencies; tot_rsp_if, tot_apb_cfg, tot_trim and tile_overlap_trimmer import this package.
package tot_pkg;

	// Request kinds on the input channel
	localparam logic REQ_CAND  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Result status codes
	localparam int STATUS_W = 3;
	localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TRIMMED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

	// Configuration port
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_LSB = 2;
	localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;
	localparam logic [REG_IDX_W-1:0] REG_MIN_MATCH = 1'b0;

	localparam int MIN_LEN_W = 16;
	localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 16'd8;

	// Outcome of checking the candidate against one stored tile
	typedef struct packed {
		logic drop;
		logic changed;
	} trim_flags_t;

endpackage

@@ rtl/core/tot_req_if.sv @@
// Request channel of the tile overlap trimmer: valid/ready plus candidate fields.
// Depends on nothing.
interface tot_req_if #(
	parameter int POS_BITS = 16
) ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [POS_BITS-1:0] first_pos;
	logic [POS_BITS-1:0] second_pos;
	logic [POS_BITS-1:0] length;

	modport source (output valid, req_type, first_pos, second_pos, length, input ready);
	modport sink   (input valid, req_type, first_pos, second_pos, length, output ready);
endinterface

@@ rtl/core/tot_rsp_if.sv @@
// Result channel of the tile overlap trimmer: valid/ready plus result fields.
// Depends on tot_pkg for the status width.
interface tot_rsp_if
	import tot_pkg::*;
#(
	parameter int POS_BITS = 16,
	parameter int CNT_W    = 9
) ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_BITS-1:0] trimmed_first_pos;
	logic [POS_BITS-1:0] trimmed_second_pos;
	logic [POS_BITS-1:0] trimmed_length;
	logic [CNT_W-1:0]    tiles_held;

	modport source (output valid, status, trimmed_first_pos, trimmed_second_pos,
		trimmed_length, tiles_held, input ready);
	modport sink   (input valid, status, trimmed_first_pos, trimmed_second_pos,
		trimmed_length, tiles_held, output ready);
endinterface

@@ rtl/core/tot_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tot_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/core/tot_apb_cfg.sv @@
// APB-style configuration register bank holding min_match_length.
// Depends on tot_pkg for address layout and reset value.
module tot_apb_cfg
	import tot_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [MIN_LEN_W-1:0]  min_len
);
	logic [MIN_LEN_W-1:0] min_len_q;
	logic                 sel_min;

	assign pready  = 1'b1;
	assign sel_min = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_MIN_MATCH);
	assign min_len = min_len_q;
	assign prdata  = sel_min ? APB_DATA_W'(min_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RST;
		end else if (psel && penable && pwrite && pready && sel_min) begin
			min_len_q <= pwdata[MIN_LEN_W-1:0];
		end
	end
endmodule

@@ rtl/core/tot_trim.sv @@
// Overlap check of the candidate against one stored tile, first sequence then second.
// Depends on tot_pkg for trim_flags_t.
module tot_trim
	import tot_pkg::*;
#(
	parameter int POS_BITS = 16
) (
	input  logic [POS_BITS:0]    cand_a,
	input  logic [POS_BITS:0]    cand_b,
	input  logic [POS_BITS:0]    cand_n,
	input  logic [POS_BITS-1:0]  tile_a,
	input  logic [POS_BITS-1:0]  tile_b,
	input  logic [POS_BITS-1:0]  tile_n,
	input  logic [MIN_LEN_W-1:0] min_len,
	output logic [POS_BITS:0]    next_a,
	output logic [POS_BITS:0]    next_b,
	output logic [POS_BITS:0]    next_n,
	output trim_flags_t          flags
);
	localparam int EW    = POS_BITS + 1;
	localparam int CMP_W = (EW > MIN_LEN_W) ? EW : MIN_LEN_W;

	typedef struct packed {
		logic [EW-1:0] p;
		logic [EW-1:0] q;
		logic [EW-1:0] n;
		logic          hit;
		logic          drop;
	} seq_res_t;

	// p is this sequence's start, q the other's. The candidate end cend stays
	// fixed under a head cut, so the new length is cend - tend; a tail cut only
	// happens with p below ts, leaving ts - p.
	function automatic seq_res_t check_seq(
		input logic [EW-1:0]        p,
		input logic [EW-1:0]        q,
		input logic [EW-1:0]        n,
		input logic [POS_BITS-1:0]  ts,
		input logic [POS_BITS-1:0]  tl,
		input logic [CMP_W-1:0]     minl
	);
		seq_res_t      r;
		logic [EW-1:0] tend;
		logic [EW-1:0] cend;
		logic [EW-1:0] ts_x;
		logic          head;
		logic          tail;
		ts_x   = EW'(ts);
		tend   = ts_x + EW'(tl);
		cend   = p + n;
		head   = (p >= ts_x) && (p < tend);
		tail   = !head && (cend > ts_x) && (cend < tend);
		r.p    = p;
		r.q    = q;
		r.n    = n;
		r.hit  = head || tail;
		r.drop = 1'b0;
		if (head) begin
			r.drop = (cend < tend) || (CMP_W'(cend - tend) < minl);
			r.n    = cend - tend;
			r.p    = tend;
			r.q    = q + (tend - p);
		end else if (tail) begin
			r.drop = CMP_W'(ts_x - p) < minl;
			r.n    = ts_x - p;
		end
		return r;
	endfunction

	seq_res_t         r1;
	seq_res_t         r2;
	logic [CMP_W-1:0] minl;

	assign minl = CMP_W'(min_len);

	// Second check runs on the second sequence: its own start is b, the other a
	always_comb begin
		r1            = check_seq(cand_a, cand_b, cand_n, tile_a, tile_n, minl);
		r2            = check_seq(r1.q, r1.p, r1.n, tile_b, tile_n, minl);
		next_a        = r2.q;
		next_b        = r2.p;
		next_n        = r2.n;
		flags.drop    = r1.drop || r2.drop;
		flags.changed = r1.hit || r2.hit;
	end
endmodule

@@ rtl/core/tile_overlap_trimmer.sv @@
// Top level of the tile overlap trimmer: request/result channels, APB config,
// scan control and result register. Depends on tot_pkg, tot_req_if, tot_rsp_if,
// tot_ram, tot_apb_cfg and tot_trim.
//
// The tile table (first start, second start, length) lives in one RAM of
// MAX_TILES rows with a registered read. A candidate is checked against the
// stored tiles in storage order, one tile per cycle: the read of row k+1 is
// in flight while row k is checked. A candidate passes a transfer, a scan of
// the stored rows and a finish step, where the finish waits for a free output
// register; the scan stops early when a trim drops it. A clear request or a
// candidate against an empty table goes from transfer straight to finish. One
// item is in work at a time and the next transfer is taken once the previous
// result sits in the output register, even if that result has not yet been
// taken. An untrimmed candidate is written, if the table is not full, to the
// row at index tiles_held in its finish cycle; no read is issued then, so no
// bypass is needed. min_match_length sits at byte address 0 of the APB port;
// write it only while the block is idle.
module tile_overlap_trimmer
	import tot_pkg::*;
#(
	parameter int MAX_TILES = 256,
	parameter int POS_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	tot_req_if.sink               req,
	tot_rsp_if.source             rsp
);
	localparam int EW   = POS_BITS + 1;
	localparam int AW   = $clog2(MAX_TILES);
	localparam int CW   = $clog2(MAX_TILES + 1);
	localparam int RW   = 3 * POS_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]           state_q;
	logic [EW-1:0]        cand_a_q, cand_b_q, cand_n_q;
	logic                 clear_q, dropped_q, changed_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rd_ptr_q;
	logic                 data_vld_s1, last_s1;
	logic [MIN_LEN_W-1:0] min_len;

	logic                 req_xfer, rd_en, out_free, finish, full, store;
	logic [RW-1:0]        rd_data, wr_data;
	logic [EW-1:0]        next_a, next_b, next_n;
	trim_flags_t          flags;

	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [POS_BITS-1:0]  out_a_q, out_b_q, out_n_q;
	logic [CW-1:0]        held_q;

	tot_apb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.min_len (min_len)
	);

	// Accept a new item only between items
	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;

	// Issue one table read per scan cycle until all stored rows are out
	assign rd_en    = (state_q == S_SCAN) && (rd_ptr_q < count_q);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign finish   = (state_q == S_FIN) && out_free;
	assign full     = (count_q == CW'(MAX_TILES));
	assign store    = finish && !clear_q && !dropped_q && !changed_q && !full;
	assign wr_data  = {cand_a_q[POS_BITS-1:0], cand_b_q[POS_BITS-1:0],
		cand_n_q[POS_BITS-1:0]};

	tot_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_TILES)
	) u_tiles (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rd_data)
	);

	tot_trim #(
		.POS_BITS (POS_BITS)
	) u_trim (
		.cand_a  (cand_a_q),
		.cand_b  (cand_b_q),
		.cand_n  (cand_n_q),
		.tile_a  (rd_data[3*POS_BITS-1:2*POS_BITS]),
		.tile_b  (rd_data[2*POS_BITS-1:POS_BITS]),
		.tile_n  (rd_data[POS_BITS-1:0]),
		.min_len (min_len),
		.next_a  (next_a),
		.next_b  (next_b),
		.next_n  (next_n),
		.flags   (flags)
	);

	// Scan control and candidate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			data_vld_s1 <= 1'b0;
			last_s1     <= 1'b0;
			clear_q     <= 1'b0;
			dropped_q   <= 1'b0;
			changed_q   <= 1'b0;
		end else begin
			data_vld_s1 <= rd_en;
			last_s1     <= (rd_ptr_q == count_q - CW'(1));
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						clear_q   <= (req.req_type == REQ_CLEAR);
						dropped_q <= 1'b0;
						changed_q <= 1'b0;
						rd_ptr_q  <= '0;
						if (req.req_type == REQ_CLEAR || count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Check the row that arrived; stop at the first drop
					if (data_vld_s1) begin
						if (flags.drop) begin
							dropped_q <= 1'b1;
							state_q   <= S_FIN;
						end else begin
							changed_q <= changed_q || flags.changed;
							if (last_s1) begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (clear_q) begin
							count_q <= '0;
						end else if (store) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Candidate payload: load on transfer, advance on each surviving check
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cand_a_q <= EW'(req.first_pos);
			cand_b_q <= EW'(req.second_pos);
			cand_n_q <= EW'(req.length);
		end else if (state_q == S_SCAN && data_vld_s1 && !flags.drop) begin
			cand_a_q <= next_a;
			cand_b_q <= next_b;
			cand_n_q <= next_n;
		end
	end

	// Output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			priority if (clear_q) begin
				status_q <= ST_CLEARED;
				out_a_q  <= '0;
				out_b_q  <= '0;
				out_n_q  <= '0;
				held_q   <= '0;
			end else if (dropped_q) begin
				status_q <= ST_DROPPED;
				out_a_q  <= '0;
				out_b_q  <= '0;
				out_n_q  <= '0;
				held_q   <= count_q;
			end else if (changed_q) begin
				status_q <= ST_TRIMMED;
				out_a_q  <= cand_a_q[POS_BITS-1:0];
				out_b_q  <= cand_b_q[POS_BITS-1:0];
				out_n_q  <= cand_n_q[POS_BITS-1:0];
				held_q   <= count_q;
			end else if (full) begin
				status_q <= ST_FULL;
				out_a_q  <= cand_a_q[POS_BITS-1:0];
				out_b_q  <= cand_b_q[POS_BITS-1:0];
				out_n_q  <= cand_n_q[POS_BITS-1:0];
				held_q   <= count_q;
			end else begin
				status_q <= ST_STORED;
				out_a_q  <= cand_a_q[POS_BITS-1:0];
				out_b_q  <= cand_b_q[POS_BITS-1:0];
				out_n_q  <= cand_n_q[POS_BITS-1:0];
				held_q   <= count_q + CW'(1);
			end
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.status             = status_q;
	assign rsp.trimmed_first_pos  = out_a_q;
	assign rsp.trimmed_second_pos = out_b_q;
	assign rsp.trimmed_length     = out_n_q;
	assign rsp.tiles_held         = held_q;
endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for tile_overlap_trimmer: APB setup of the minimum match length,
// candidate and clear requests in, one result per request out, checked against a predictor.
// Depends on tot_pkg, tot_req_if, tot_rsp_if and the RTL of the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tot_pkg::*;

	localparam int MAX_TILES = 256;
	localparam int POS_BITS  = 16;
	localparam int CNT_W     = 9;

	localparam logic [APB_ADDR_W-1:0] ADDR_MIN_MATCH = APB_ADDR_W'(REG_MIN_MATCH) << REG_IDX_LSB;
	// first index past the register map; writes there must leave the block alone
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED  = APB_ADDR_W'(1) << REG_IDX_LSB;

	typedef struct packed {
		logic                req_type;
		logic [POS_BITS-1:0] first_pos;
		logic [POS_BITS-1:0] second_pos;
		logic [POS_BITS-1:0] length;
	} tile_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_BITS-1:0] first_pos;
		logic [POS_BITS-1:0] second_pos;
		logic [POS_BITS-1:0] length;
		logic [CNT_W-1:0]    held;
	} tile_rsp_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tot_req_if #(.POS_BITS(POS_BITS)) req_ch ();
	tot_rsp_if #(.POS_BITS(POS_BITS), .CNT_W(CNT_W)) rsp_ch ();

	tile_overlap_trimmer #(.MAX_TILES(MAX_TILES), .POS_BITS(POS_BITS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// Predictor copy of the tile table and of the minimum match length.
	logic [POS_BITS-1:0] tbl_first  [MAX_TILES];
	logic [POS_BITS-1:0] tbl_second [MAX_TILES];
	logic [POS_BITS-1:0] tbl_len    [MAX_TILES];
	int                  tbl_count = 0;
	int unsigned         min_len   = 32'(MIN_LEN_RST);

	// Outcomes still owed by the block, oldest first, and trimmed tiles waiting
	// to be offered again within the current sequence pair.
	tile_rsp_t pending_outcomes [$];
	tile_req_t requeue_tiles    [$];

	int fail_count = 0;

	// Idle controls: random gaps on the request side, random stalls on the result side.
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;

	// Long hold-off on the result side, started by bumping hold_seq.
	int hold_seq  = 0;
	int hold_len  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Check one sequence of the candidate against one stored tile. p is the start
	// in this sequence, q the start in the other; both advance on a head trim.
	// Sums stay 32 bits wide so a tile end past the position range does not wrap.
	task automatic trim_one_seq(input int unsigned ts, input int unsigned tl,
		inout int unsigned p, inout int unsigned q, inout int unsigned n,
		inout bit changed, output bit keep);
		int unsigned tend;
		int unsigned cend;
		int unsigned cut;
		tend = ts + tl;
		cend = p + n;
		keep = 1'b1;
		if (p >= ts && p < tend) begin
			// head overlap: move both starts past the stored tile
			cut = tend - p;
			if (cut > n || n - cut < min_len) begin
				keep = 1'b0;
			end else begin
				n -= cut;
				p += cut;
				q += cut;
				changed = 1'b1;
			end
		end else if (cend > ts && cend < tend) begin
			// tail overlap: shorten only
			cut = cend - ts;
			if (cut > n || n - cut < min_len) begin
				keep = 1'b0;
			end else begin
				n -= cut;
				changed = 1'b1;
			end
		end
	endtask

	task automatic predict_outcome(input tile_req_t r, output tile_rsp_t e);
		int unsigned a;
		int unsigned b;
		int unsigned n;
		bit          changed;
		bit          keep;
		bit          dropped;
		int          k;
		a = 32'(r.first_pos);
		b = 32'(r.second_pos);
		n = 32'(r.length);
		changed = 1'b0;
		dropped = 1'b0;
		if (r.req_type == REQ_CLEAR) begin
			tbl_count = 0;
			e.status = ST_CLEARED;
			a = 0;
			b = 0;
			n = 0;
		end else begin
			// scan in storage order; a drop ends the scan at once
			for (k = 0; k < tbl_count && !dropped; k++) begin
				trim_one_seq(32'(tbl_first[k]), 32'(tbl_len[k]), a, b, n, changed, keep);
				if (keep) begin
					trim_one_seq(32'(tbl_second[k]), 32'(tbl_len[k]), b, a, n, changed,
						keep);
				end
				if (!keep) begin
					dropped = 1'b1;
				end
			end
			if (dropped) begin
				e.status = ST_DROPPED;
				a = 0;
				b = 0;
				n = 0;
			end else if (changed) begin
				e.status = ST_TRIMMED;
			end else if (tbl_count >= MAX_TILES) begin
				e.status = ST_FULL;
			end else begin
				tbl_first[tbl_count]  = a[POS_BITS-1:0];
				tbl_second[tbl_count] = b[POS_BITS-1:0];
				tbl_len[tbl_count]    = n[POS_BITS-1:0];
				tbl_count++;
				e.status = ST_STORED;
			end
		end
		// trimmed starts past the position range wrap in the result fields
		e.first_pos  = a[POS_BITS-1:0];
		e.second_pos = b[POS_BITS-1:0];
		e.length     = n[POS_BITS-1:0];
		e.held       = CNT_W'(tbl_count);
	endtask

	// ------------------------------------------------------------------
	// Channel and register drivers
	// ------------------------------------------------------------------

	// Offer one request and hold it until its transfer. Predict at offer time;
	// requests are accepted in order, so the outcome queue stays in step.
	// Leave valid high on return unless a gap is drawn, so back-to-back
	// requests never lower and raise valid in one step.
	task automatic send_item(input tile_req_t r);
		tile_rsp_t e;
		tile_req_t rq;
		predict_outcome(r, e);
		pending_outcomes = {pending_outcomes, e};
		if (e.status == ST_TRIMMED) begin
			rq.req_type   = REQ_CAND;
			rq.first_pos  = e.first_pos;
			rq.second_pos = e.second_pos;
			rq.length     = e.length;
			requeue_tiles = {requeue_tiles, rq};
		end else if (e.status == ST_CLEARED) begin
			requeue_tiles.delete();
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= r.req_type;
		req_ch.first_pos  <= r.first_pos;
		req_ch.second_pos <= r.second_pos;
		req_ch.length     <= r.length;
		do @(posedge clk); while (!req_ch.ready);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_cand(input int unsigned a, input int unsigned b, input int unsigned n);
		send_item('{REQ_CAND, POS_BITS'(a), POS_BITS'(b), POS_BITS'(n)});
	endtask

	// Drop valid and hold off until every owed result has been taken.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
	endtask

	// Setup phase, access phase, then an idle clock with psel low so the next access never
	// drives psel twice in one step.
	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[APB_ADDR_W-1:REG_IDX_LSB] == REG_MIN_MATCH) begin
			min_len = 32'(data[MIN_LEN_W-1:0]);
		end
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] want);
		logic [APB_DATA_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want) begin
			report_mismatch("min_match_length readback", want, got);
		end
	endtask

	// Change the minimum match length with the block idle, then read it back.
	task automatic set_min_len(input int unsigned value);
		drain_results();
		apb_write(ADDR_MIN_MATCH, value);
		apb_read_check(ADDR_MIN_MATCH, {16'h0, min_len[MIN_LEN_W-1:0]});
	endtask

	// ------------------------------------------------------------------
	// Result side: ready pattern and checker
	// ------------------------------------------------------------------

	// Drive ready: a requested long hold-off first, then random stall bursts.
	initial begin
		int hold_seen;
		int hold_left;
		int stall_left;
		hold_seen  = 0;
		hold_left  = 0;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare every result transfer with the oldest owed outcome, field by field.
	always @(posedge clk) begin
		tile_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result status", '0, 32'(rsp_ch.status));
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
				if (rsp_ch.trimmed_first_pos !== want.first_pos)
					report_mismatch("trimmed_first_pos", 32'(want.first_pos),
						32'(rsp_ch.trimmed_first_pos));
				if (rsp_ch.trimmed_second_pos !== want.second_pos)
					report_mismatch("trimmed_second_pos", 32'(want.second_pos),
						32'(rsp_ch.trimmed_second_pos));
				if (rsp_ch.trimmed_length !== want.length)
					report_mismatch("trimmed_length", 32'(want.length),
						32'(rsp_ch.trimmed_length));
				if (rsp_ch.tiles_held !== want.held)
					report_mismatch("tiles_held", 32'(want.held), 32'(rsp_ch.tiles_held));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked requests: field extremes, each overlap kind in each sequence,
	// drops, zero-length tiles, a tile end past the position range, a start that
	// wraps after a head trim, zero and maximum minimum length, an unmapped write.
	task automatic test_directed();
		apb_read_check(ADDR_MIN_MATCH, {16'h0, MIN_LEN_RST});
		send_item('{REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_cand(0, 0, 0);                    // zero-length tile gets stored
		send_cand(0, 0, 20);                   // zero-length tile never overlaps
		send_cand(10, 1000, 20);               // head overlap, first sequence
		send_cand(1000, 10, 20);               // head overlap, second sequence
		send_cand(500, 500, 20);
		send_cand(490, 2000, 20);              // tail overlap, first sequence
		send_cand(2000, 490, 20);              // tail overlap, second sequence
		send_cand(495, 3000, 20);              // tail trim leaves too little
		send_cand(505, 4000, 20);              // head trim leaves too little
		send_cand(16'hFFFF, 16'hFFFF, 16'hFFFF); // tile end lies past the range
		send_cand(16'hFFF0, 100, 16'hFFFF);    // tail trim against that tile
		send_cand(30, 30, 10);
		send_cand(100, 25, 10);                // tail drop in second sequence
		set_min_len(0);
		send_cand(505, 6000, 15);              // trim down to nothing is kept
		send_cand(505, 6000, 14);              // cut longer than the candidate
		send_cand(16'hFFFF, 16'hFFFF, 16'hFFFF); // head trim wraps both starts
		set_min_len(32'hFFFF);
		send_cand(510, 7000, 16'hFFFF);        // any trim drops
		send_cand(9000, 9000, 1);
		// an unmapped register write must not disturb the minimum length
		drain_results();
		apb_write(ADDR_UNMAPPED, 32'h3);
		apb_read_check(ADDR_MIN_MATCH, {16'h0, min_len[MIN_LEN_W-1:0]});
		send_cand(9000, 9100, 5);
		set_min_len(32'(MIN_LEN_RST));
		send_item('{REQ_CLEAR, 16'h0, 16'h0, 16'h0});
		send_cand(100, 200, 16'hFFFF);
	endtask

	// Fill the table with disjoint tiles, then offer untrimmed candidates that
	// must come back as table full, random ones that may be trimmed, and a clear.
	task automatic test_table_full();
		tile_req_t r;
		int        k;
		set_min_len($urandom_range(1, 16));
		send_item('{REQ_CLEAR, POS_BITS'($urandom), POS_BITS'($urandom), POS_BITS'($urandom)});
		// each tile stays inside its own 256-token slot in both sequences;
		// the second sequence visits the slots in a scrambled order
		for (k = 0; k < MAX_TILES; k++) begin
			r.req_type   = REQ_CAND;
			r.first_pos  = POS_BITS'(k * 256 + $urandom_range(0, 127));
			r.second_pos = POS_BITS'(((k * 97) % 256) * 256 + $urandom_range(0, 127));
			r.length     = POS_BITS'($urandom_range(0, 128));
			send_item(r);
		end
		// the last token of every slot is free, so these are never trimmed
		for (k = 0; k < 4; k++) begin
			send_cand($urandom_range(0, 255) * 256 + 255, $urandom_range(0, 255) * 256 + 255,
				$urandom_range(0, 1));
		end
		for (k = 0; k < 4; k++) begin
			send_cand($urandom, $urandom, $urandom_range(20, 300));
		end
		send_item('{REQ_CLEAR, 16'h0, 16'h0, 16'h0});
		send_cand($urandom, $urandom, $urandom_range(0, 64));
	endtask

	// Hold the result side off for a long stretch while requests keep coming,
	// so the block backs up and stalls its input; then pause the sender until
	// every result is back.
	task automatic test_backpressure();
		logic [POS_BITS-1:0] base_a;
		logic [POS_BITS-1:0] base_b;
		int                  k;
		drain_results();
		send_idle = 1'b0;
		base_a = POS_BITS'($urandom);
		base_b = POS_BITS'($urandom);
		hold_len = 400;
		hold_seq++;
		send_item('{REQ_CLEAR, 16'h0, 16'h0, 16'h0});
		for (k = 0; k < 16; k++) begin
			send_cand(base_a + $urandom_range(0, 200), base_b + $urandom_range(0, 200),
				$urandom_range(0, 40));
		end
		drain_results();
		send_idle = 1'b1;
		for (k = 0; k < 6; k++) begin
			send_cand(base_a + $urandom_range(0, 200), base_b + $urandom_range(0, 200),
				$urandom_range(0, 40));
		end
	endtask

	// Random sequence pairs: a clear, then candidates clustered in a window so
	// they overlap, mixed with trimmed tiles offered again and some noise.
	task automatic run_tile_sessions(input int n_items);
		tile_req_t           r;
		logic [POS_BITS-1:0] base_a;
		logic [POS_BITS-1:0] base_b;
		int                  sent;
		int                  sess_len;
		int                  win;
		int                  pick;
		int                  k;
		sent = 0;
		while (sent < n_items) begin
			send_item('{REQ_CLEAR, POS_BITS'($urandom), POS_BITS'($urandom),
				POS_BITS'($urandom)});
			sent++;
			base_a   = POS_BITS'($urandom);
			base_b   = POS_BITS'($urandom);
			win      = $urandom_range(16, 1500);
			sess_len = $urandom_range(4, 60);
			for (k = 0; k < sess_len && sent < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25 && requeue_tiles.size() != 0) begin
					r = requeue_tiles.pop_front();
				end else if (pick < 33) begin
					// noise over the whole field range, now and then a stray clear
					r.req_type   = ($urandom_range(0, 9) == 0) ? REQ_CLEAR : REQ_CAND;
					r.first_pos  = POS_BITS'($urandom);
					r.second_pos = POS_BITS'($urandom);
					r.length     = POS_BITS'($urandom);
				end else begin
					r.req_type   = REQ_CAND;
					r.first_pos  = base_a + POS_BITS'($urandom_range(0, win));
					r.second_pos = base_b + POS_BITS'($urandom_range(0, win));
					case ($urandom_range(0, 9))
						7, 8:    r.length = POS_BITS'($urandom_range(0, win));
						9:       r.length = POS_BITS'($urandom);
						default: r.length = POS_BITS'($urandom_range(0, 64));
					endcase
				end
				send_item(r);
				sent++;
			end
		end
	endtask

	// Random traffic under several minimum lengths, extremes included.
	task automatic test_config_sweep();
		set_min_len(0);
		run_tile_sessions(110);
		set_min_len(1);
		run_tile_sessions(110);
		set_min_len(32'hFFFF);
		run_tile_sessions(110);
		set_min_len($urandom_range(2, 40));
		run_tile_sessions(110);
		set_min_len(3);
		run_tile_sessions(110);
		set_min_len(32'(MIN_LEN_RST));
		run_tile_sessions(110);
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_steady_stream();
		set_min_len($urandom_range(4, 12));
		send_idle = 1'b0;
		recv_idle = 1'b0;
		run_tile_sessions(200);
	endtask

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_CAND;
		req_ch.first_pos  <= '0;
		req_ch.second_pos <= '0;
		req_ch.length     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_table_full();
		test_backpressure();
		test_config_sweep();
		test_steady_stream();

		// wait out the last results, then a full scan's worth for strays
		drain_results();
		repeat (MAX_TILES + 50) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/tot_pkg.sv
rtl/core/tot_req_if.sv
rtl/core/tot_rsp_if.sv
rtl/core/tot_ram.sv
rtl/core/tot_apb_cfg.sv
rtl/core/tot_trim.sv
rtl/core/tile_overlap_trimmer.sv
sim/tb_top.sv
